// ----- hdl/nff_pkg.sv -----
`timescale 1ns / 1ps

package nff_pkg;

  // Sample width and coefficient layout of the configuration packs.
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int COEF_PACKS   = 4;
  localparam int PACK_W       = 64;
  localparam int TAP_COUNT_W  = 5;
  localparam int RECIP_W      = 24;
  localparam int RECIP_FRAC_W = 30;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_RECIP = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [PACK_W-1:0]      COEF_PACK0_RST = 64'd16384;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST  = 5'd1;
  localparam logic [RECIP_W-1:0]     NORM_RECIP_RST = 24'd65536;

  // Saturation limits.
  localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       chan;
    logic                       apply;
  } nff_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       chan_out;
  } nff_out_t;

endpackage

// ----- hdl/normalized_fir_filter_unit.sv -----
`timescale 1ns / 1ps
// Normalized FIR filter for interleaved PCM audio.
// Input beats (in_valid/in_ready) carry one signed sample, its channel and an
// apply flag. Each sample is written into its channel's history memory. With
// apply set, one multiply-accumulate unit walks the active taps, reading one
// history entry per cycle from the memory, then the sum is scaled by the
// reciprocal norm in two partial products and saturated to 16 bits.
// Result beats (out_valid/out_ready) return one sample per input beat, in
// order, with the channel echoed.
// A pass-through sample goes straight to the result register; a filtered one
// runs the tap loop, drains the pipeline, forms the magnitude and the two
// partial products, then loads. One item is in work at a time: a new input
// beat is taken only after the last result has been loaded.
// The configuration port (cfg_valid/cfg_ready) is always ready and is meant
// to be written only while the block is idle.
// Reset is synchronous: the history reads as zero afterwards (per-channel fill
// counts, no clearing pass), registers take their reset values and both
// channels are empty. When the receiver stalls, the finished result waits in
// the output register; the next input beat is still taken and worked on, and
// its result waits until the output register is free.

module normalized_fir_filter_unit #(
  parameter int TAPS     = 16,
  parameter int CHANNELS = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  nff_pkg::nff_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output nff_pkg::nff_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nff_pkg::PACK_W-1:0]     cfg_data
);

  import nff_pkg::*;

  localparam int DEPTH = CHANNELS * TAPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int KW    = $clog2(TAPS + 1);
  localparam int ACC_W = 2 * SAMPLE_W + 1 + $clog2(TAPS);
  localparam int HI_W  = ACC_W - 16;
  localparam int LO_P  = 16 + RECIP_W;
  localparam int HI_P  = HI_W + RECIP_W;
  localparam int TOT_W = ACC_W + RECIP_W;
  localparam int Q_W   = TOT_W - RECIP_FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DRAIN, S_MAG, S_MUL_LO, S_MUL_HI, S_FIN
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [PACK_W-1:0]      coef_pack_r [COEF_PACKS];
  logic [TAP_COUNT_W-1:0] tap_count_r;
  logic [RECIP_W-1:0]     norm_recip_r;

  // History memory and per-channel ring pointers and fill counts.
  logic [SAMPLE_W-1:0] hist_mem [DEPTH];
  logic [SAMPLE_W-1:0] mem_q_r;
  logic [PW-1:0]       wptr_r [CHANNELS];
  logic [KW-1:0]       fill_r [CHANNELS];

  // Item context.
  logic                       c_r;
  logic                       chan_r;
  logic                       apply_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [PW-1:0]              base_r;
  logic [KW-1:0]              cur_fill_r;
  logic [KW-1:0]              n_r;
  logic [KW-1:0]              rk_r;

  // Multiply-accumulate pipeline.
  logic                       v1_r;
  logic                       v2_r;
  logic                       ok1_r;
  logic [KW-1:0]              k1_r;
  logic signed [31:0]         prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       neg_r;
  logic [ACC_W-1:0]           mag_r;
  logic [LO_P-1:0]            lo_r;
  logic [HI_P-1:0]            hi_r;

  logic                       out_valid_r;
  nff_out_t                   out_data_r;

  logic                       c_in;
  logic                       in_fire;
  logic                       out_free;
  logic                       mem_we;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic [KW:0]                ring_sum;
  logic [KW:0]                ring_idx;
  logic [3:0]                 k4;
  logic signed [COEF_W-1:0]   coef1;
  logic signed [SAMPLE_W-1:0] tap_data;
  logic [TOT_W-1:0]           total;
  logic [Q_W-1:0]             q_mag;
  logic [SAMPLE_W-1:0]        filt_res;
  logic [KW-1:0]              n_in;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // A channel beyond the supported count folds onto the last one.
  assign c_in = (CHANNELS > 1) ? in_data.chan : 1'b0;

  // Clamp the tap count into 1..TAPS.
  always_comb begin
    if (tap_count_r == '0) begin
      n_in = KW'(1);
    end else if (32'(tap_count_r) > TAPS) begin
      n_in = KW'(TAPS);
    end else begin
      n_in = KW'(tap_count_r);
    end
  end

  // Write port: the new sample goes to its channel's ring position.
  assign mem_we = in_fire;
  assign waddr  = c_in ? AW'(TAPS) + AW'(wptr_r[c_in]) : AW'(wptr_r[c_in]);

  // Read port: the sample rk_r steps back in the current channel's ring.
  always_comb begin
    ring_sum = (KW+1)'(base_r) + (KW+1)'(TAPS) - (KW+1)'(rk_r);
    if (32'(ring_sum) >= TAPS) begin
      ring_idx = ring_sum - (KW+1)'(TAPS);
    end else begin
      ring_idx = ring_sum;
    end
  end

  assign raddr = c_r ? AW'(TAPS) + AW'(ring_idx) : AW'(ring_idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[waddr] <= in_data.sample_in;
    end
    mem_q_r <= hist_mem[raddr];
  end

  // Coefficient of the tap now at the multiplier; unfilled history reads zero.
  assign k4       = 4'(k1_r);
  assign coef1    = $signed(coef_pack_r[k4[3:2]][{k4[1:0], 4'b0000} +: COEF_W]);
  assign tap_data = ok1_r ? $signed(mem_q_r) : '0;

  // Scaled magnitude, truncated toward zero, then saturated with its sign.
  always_comb begin
    total = {hi_r, 16'b0} + TOT_W'(lo_r);
    q_mag = total[TOT_W-1:RECIP_FRAC_W];
    if (neg_r) begin
      if (q_mag > Q_W'(SAT_NEG)) begin
        filt_res = SAT_NEG;
      end else begin
        filt_res = SAMPLE_W'(0) - q_mag[SAMPLE_W-1:0];
      end
    end else begin
      if (q_mag > Q_W'(SAT_POS)) begin
        filt_res = SAT_POS;
      end else begin
        filt_res = q_mag[SAMPLE_W-1:0];
      end
    end
  end

  // Sequencer, configuration registers and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      coef_pack_r[0] <= COEF_PACK0_RST;
      for (int p = 1; p < COEF_PACKS; p++) begin
        coef_pack_r[p] <= '0;
      end
      tap_count_r  <= TAP_COUNT_RST;
      norm_recip_r <= NORM_RECIP_RST;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        wptr_r[ch] <= '0;
        fill_r[ch] <= '0;
      end
    end else begin
      // Configuration writes; indexes beyond the list are dropped.
      if (cfg_valid) begin
        if (cfg_index <= CFG_COEF_LAST) begin
          coef_pack_r[cfg_index[1:0]] <= cfg_data;
        end else if (cfg_index == CFG_TAP_COUNT) begin
          tap_count_r <= cfg_data[TAP_COUNT_W-1:0];
        end else if (cfg_index == CFG_NORM_RECIP) begin
          norm_recip_r <= cfg_data[RECIP_W-1:0];
        end
      end

      // A taken result frees the output register; in S_FIN the load decides.
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      // Multiply-accumulate pipeline stages.
      v1_r  <= (state_r == S_READ);
      k1_r  <= rk_r;
      ok1_r <= (rk_r < cur_fill_r);
      v2_r  <= v1_r;
      if (v1_r) begin
        prod_r <= coef1 * tap_data;
      end
      if (v2_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            c_r      <= c_in;
            chan_r   <= in_data.chan;
            apply_r  <= in_data.apply;
            sample_r <= in_data.sample_in;
            base_r   <= wptr_r[c_in];
            n_r      <= n_in;
            rk_r     <= '0;
            acc_r    <= '0;
            if (32'(wptr_r[c_in]) == TAPS - 1) begin
              wptr_r[c_in] <= '0;
            end else begin
              wptr_r[c_in] <= wptr_r[c_in] + PW'(1);
            end
            if (32'(fill_r[c_in]) == TAPS) begin
              cur_fill_r <= fill_r[c_in];
            end else begin
              fill_r[c_in] <= fill_r[c_in] + KW'(1);
              cur_fill_r   <= fill_r[c_in] + KW'(1);
            end
            state_r <= in_data.apply ? S_READ : S_FIN;
          end
        end
        S_READ: begin
          rk_r <= rk_r + KW'(1);
          if ((rk_r + KW'(1)) == n_r) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) begin
            state_r <= S_MAG;
          end
        end
        S_MAG: begin
          neg_r   <= acc_r[ACC_W-1];
          mag_r   <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
          state_r <= S_MUL_LO;
        end
        S_MUL_LO: begin
          lo_r    <= mag_r[15:0] * norm_recip_r;
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          hi_r    <= mag_r[ACC_W-1:16] * norm_recip_r;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r         <= 1'b1;
            out_data_r.chan_out <= chan_r;
            out_data_r.sample_out <= apply_r ? $signed(filt_res) : sample_r;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The tap pipeline is empty whenever a new beat can be taken.
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!v1_r && !v2_r))
    else $error("tap pipeline busy while idle");

  // An accepted beat always starts work.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_READ || state_r == S_FIN))
    else $error("accepted beat did not start");

  // Tap reads stay within the active tap count.
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (rk_r < n_r))
    else $error("tap index beyond tap count");

  // A result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("result left while output was stalled");

endmodule

// ----- tb/nff_checker.sv -----
`timescale 1ns / 1ps

module nff_checker
  import nff_pkg::*;
#(
  parameter int TAPS     = 16,
  parameter int CHANNELS = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  nff_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  nff_out_t              out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PACK_W-1:0]     cfg_data,
  output int                    errors,
  output int                    pending
);

  // Shadow copy of the filter settings and of the per-channel sample history.
  logic [PACK_W-1:0]          coef_cfg [COEF_PACKS];
  logic [TAP_COUNT_W-1:0]     tap_cfg;
  logic [RECIP_W-1:0]         recip_cfg;
  logic signed [SAMPLE_W-1:0] hist [CHANNELS][TAPS];

  // Results still owed by the block, oldest first.
  nff_out_t expected_samples[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Normalized FIR sum over the active taps of one channel's history.
  // The magnitude is truncated, then clamped to the 16-bit range.
  function automatic logic [SAMPLE_W-1:0] filtered_value(input int c);
    longint                   acc;
    longint unsigned          mag;
    int                       ntaps;
    logic signed [COEF_W-1:0] coef;
    logic                     neg;
    acc = 0;
    ntaps = (tap_cfg == 0) ? 1 : ((tap_cfg > TAPS) ? TAPS : int'(tap_cfg));
    for (int k = 0; k < ntaps; k++) begin
      coef = coef_cfg[k / 4][COEF_W * (k % 4) +: COEF_W];
      acc += longint'(coef) * longint'(hist[c][k]);
    end
    neg = (acc < 0);
    mag = neg ? longint'(0) - acc : acc;
    mag = (mag * longint'(recip_cfg)) >> RECIP_FRAC_W;
    if (neg) begin
      if (mag > 64'd32768) mag = 64'd32768;
      return SAMPLE_W'(64'd0 - mag);
    end
    if (mag > 64'd32767) mag = 64'd32767;
    return SAMPLE_W'(mag);
  endfunction

  always @(posedge clk) begin
    nff_out_t want;
    nff_out_t got;
    int       c;
    if (!rst_n) begin
      coef_cfg[0] = COEF_PACK0_RST;
      for (int p = 1; p < COEF_PACKS; p++) coef_cfg[p] = '0;
      tap_cfg   = TAP_COUNT_RST;
      recip_cfg = NORM_RECIP_RST;
      for (int ch = 0; ch < CHANNELS; ch++)
        for (int k = 0; k < TAPS; k++) hist[ch][k] = '0;
      expected_samples.delete();
    end else begin
      // Register writes; indexes past the list are dropped.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= CFG_COEF_LAST)
          coef_cfg[cfg_index[1:0]] = cfg_data;
        else if (cfg_index == CFG_TAP_COUNT)
          tap_cfg = cfg_data[TAP_COUNT_W-1:0];
        else if (cfg_index == CFG_NORM_RECIP)
          recip_cfg = cfg_data[RECIP_W-1:0];
      end

      // Result beat: compare against the oldest expectation.
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_samples.size() == 0) begin
          $error("result beat with nothing expected: sample_out %0d, chan_out %0d",
                 got.sample_out, got.chan_out);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (got.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, actual %0d", want.sample_out, got.sample_out);
            errors++;
          end
          if (got.chan_out !== want.chan_out) begin
            $error("chan_out: expected %0d, actual %0d", want.chan_out, got.chan_out);
            errors++;
          end
        end
      end

      // Input beat: every sample enters its channel's history first.
      if (in_valid && in_ready) begin
        c = (int'(in_data.chan) < CHANNELS) ? int'(in_data.chan) : CHANNELS - 1;
        for (int k = TAPS - 1; k > 0; k--) hist[c][k] = hist[c][k-1];
        hist[c][0] = in_data.sample_in;
        want.chan_out   = in_data.chan;
        want.sample_out = in_data.apply ? filtered_value(c) : in_data.sample_in;
        expected_samples = {expected_samples, want};
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ----- tb/tb_normalized_fir_filter_unit.sv -----
`timescale 1ns / 1ps

module tb_normalized_fir_filter_unit;
  import nff_pkg::*;

  localparam int TAPS         = 16;
  localparam int CHANNELS     = 2;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 110;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [COEF_W-1:0]    COEF_MAX     = 16'h7FFF;
  localparam logic [COEF_W-1:0]    COEF_MIN     = 16'h8000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_NORM_RECIP + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP  = '1;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  nff_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  nff_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PACK_W-1:0]    cfg_data  = '0;

  int  check_errors;
  int  pending;
  int  cycle_count    = 0;
  int  stall_left     = 0;
  int  samples_sent   = 0;
  int  samples_filt   = 0;
  int  settings_count = 1;
  bit  gaps_on        = 1'b1;
  bit  stalls_on      = 1'b1;

  always #6 clk = ~clk;

  normalized_fir_filter_unit #(
    .TAPS     (TAPS),
    .CHANNELS (CHANNELS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nff_checker #(
    .TAPS     (TAPS),
    .CHANNELS (CHANNELS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (check_errors),
    .pending   (pending)
  );

  // Receiver back-pressure: random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (stalls_on && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(1, 11);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run stopped after %0d cycles with %0d results outstanding",
             cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Send one sample beat, with an optional idle burst ahead of it.
  // Valid is left high on return so back-to-back beats need no re-raise.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value,
                             input logic ch, input logic filt);
    nff_in_t item;
    item.sample_in = value;
    item.chan      = ch;
    item.apply     = filt;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    if (filt) samples_filt++;
  endtask

  // Drop valid and wait until every owed result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PACK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load a full filter setting while the block is idle.
  task automatic configure(input logic [PACK_W-1:0] pack0, input logic [PACK_W-1:0] pack1,
                           input logic [PACK_W-1:0] pack2, input logic [PACK_W-1:0] pack3,
                           input logic [PACK_W-1:0] taps_word,
                           input logic [PACK_W-1:0] recip_word,
                           input bit poke_unmapped);
    drain();
    write_reg(CFG_COEF_LAST - 3'd3, pack0);
    write_reg(CFG_COEF_LAST - 3'd2, pack1);
    if (poke_unmapped) write_reg(CFG_UNMAPPED, {$urandom, $urandom});
    write_reg(CFG_COEF_LAST - 3'd1, pack2);
    write_reg(CFG_COEF_LAST, pack3);
    write_reg(CFG_TAP_COUNT, taps_word);
    if (poke_unmapped) write_reg(CFG_IDX_TOP, {$urandom, $urandom});
    write_reg(CFG_NORM_RECIP, recip_word);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // Coefficients lean toward the range extremes and zero.
  function automatic logic [PACK_W-1:0] rand_pack();
    logic [PACK_W-1:0] w;
    w = {$urandom, $urandom};
    for (int t = 0; t < 4; t++) begin
      case ($urandom_range(0, 9))
        0: w[COEF_W*t +: COEF_W] = COEF_MAX;
        1: w[COEF_W*t +: COEF_W] = COEF_MIN;
        2: w[COEF_W*t +: COEF_W] = '0;
        3, 4, 5: w[COEF_W*t +: COEF_W] = COEF_W'($urandom_range(0, 8192) - 4096);
        default: ;
      endcase
    end
    return w;
  endfunction

  // Tap counts include zero and values past TAPS; upper data bits are junk.
  function automatic logic [PACK_W-1:0] rand_taps_word();
    logic [PACK_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w[TAP_COUNT_W-1:0] = '0;
      1: w[TAP_COUNT_W-1:0] = TAP_COUNT_W'($urandom_range(TAPS + 1, (1 << TAP_COUNT_W) - 1));
      2: w[TAP_COUNT_W-1:0] = TAP_COUNT_W'(TAPS);
      default: w[TAP_COUNT_W-1:0] = TAP_COUNT_W'($urandom_range(1, TAPS));
    endcase
    return w;
  endfunction

  function automatic logic [PACK_W-1:0] rand_recip_word();
    logic [PACK_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w[RECIP_W-1:0] = '0;
      1: w[RECIP_W-1:0] = '1;
      2, 3, 4, 5: w[RECIP_W-1:0] = RECIP_W'($urandom_range(256, 65536));
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return SAMPLE_W'($urandom_range(0, 64) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic ch;
    logic filt;
    bit   interleave;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings pass samples through the identity tap; history starts empty.
    send_sample(16'sd0, 1'b0, 1'b1);
    send_sample(16'sh7FFF, 1'b0, 1'b1);
    send_sample(16'sh8000, 1'b1, 1'b1);
    send_sample(-16'sd1, 1'b1, 1'b0);
    send_sample(16'sd1, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b0);
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sd12345, 1'b1, 1'b1);

    // Largest coefficients, all taps, full gain: both saturation limits.
    configure({4{COEF_MAX}}, {4{COEF_MAX}}, {4{COEF_MAX}}, {4{COEF_MAX}},
              64'hFFFF_FFFF_FFFF_FFF0, '1, 1'b0);
    repeat (3) send_sample(16'sh7FFF, 1'b0, 1'b1);
    repeat (3) send_sample(16'sh8000, 1'b1, 1'b1);
    send_sample(16'sh8000, 1'b0, 1'b1);

    // Zero gain and a zero tap count; unmapped registers written too.
    configure({4{COEF_MIN}}, {4{COEF_MIN}}, {4{COEF_MIN}}, {4{COEF_MIN}},
              64'h20, 64'hFF00_0000, 1'b1);
    send_sample(16'sh7FFF, 1'b0, 1'b1);
    send_sample(16'sh8000, 1'b1, 1'b1);
    send_sample(16'sd100, 1'b0, 1'b0);
    send_sample(16'sd4321, 1'b1, 1'b1);

    // Tap count past the end, most negative coefficients at unity gain.
    configure({4{COEF_MIN}}, {4{COEF_MIN}}, {4{COEF_MIN}}, {4{COEF_MIN}},
              64'h1F, 64'(NORM_RECIP_RST), 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b1);
    send_sample(16'sh7FFF, 1'b1, 1'b1);
    send_sample(16'sh7FFF, 1'b1, 1'b1);
    send_sample(-16'sd2, 1'b0, 1'b1);

    // Random settings with mostly interleaved stereo streams and apply runs.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      configure(rand_pack(), rand_pack(), rand_pack(), rand_pack(),
                rand_taps_word(), rand_recip_word(), $urandom_range(0, 3) == 0);
      gaps_on    = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stalls_on  = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      interleave = ($urandom_range(0, 3) != 0);
      ch   = 1'b1;
      filt = 1'b1;
      repeat (PHASE_ITEMS) begin
        if (interleave) ch = ~ch;
        else ch = $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0) filt = ~filt;
        send_sample(rand_sample(), ch, filt);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples (%0d filtered, %0d passed) across %0d filter settings.",
             samples_sent, samples_filt, samples_sent - samples_filt, settings_count);
    $display("Settings spanned saturating and zero gain, zero and oversized tap counts.");
    if (check_errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
